[hw/rtl/echo_range_seven_segment_display_assert.svh]
// Assertion helpers shared by the rangefinder modules.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef ECHO_RANGE_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH
`define ECHO_RANGE_SEVEN_SEGMENT_DISPLAY_ASSERT_SVH

`define ERSSD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`define ERSSD_ASSERT_SAME(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

[hw/rtl/erssd_pkg.sv]
package erssd_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int DIST_BITS          = 14;
  localparam int DIST_MAX           = 9999;
  localparam int DWELL_BITS         = 16;
  localparam logic [DWELL_BITS-1:0] DWELL_RESET = 16'd625;

  // 8 us per tick over 58 us per centimeter reduces to 4/29.
  localparam int TICK_SHIFT  = 2;
  localparam int CM_DIVISOR  = 29;
  localparam int CM_DIV_BITS = 5;

  localparam int SEG_BITS       = 8;
  localparam int POS_BITS       = 2;
  localparam int NUM_DIGITS     = 4;
  localparam int BCD_BITS       = 4;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 32;

  typedef logic [BCD_BITS-1:0] bcd_t;
  typedef logic [NUM_DIGITS-1:0][BCD_BITS-1:0] bcd_word_t;

  typedef struct packed {
    logic                done;
    logic [POS_BITS-1:0] pos;
  } beat_tag_t;

  // Number of divide-by-ten steps needed so that the largest distance fits four digits.
  function automatic int decade_stages(int count_bits);
    logic [63:0] q;
    int          n;
    int          i;
    q = (((64'd1 << count_bits) - 64'd1) << TICK_SHIFT) / CM_DIVISOR;
    n = 0;
    for (i = 0; i < 10; i++) begin
      if (q > DIST_MAX) begin
        q = q / 10;
        n = n + 1;
      end
    end
    return n;
  endfunction

  function automatic logic [SEG_BITS-1:0] seg_of(bcd_t d);
    logic [SEG_BITS-1:0] s;
    case (d)
      4'd0:    s = 8'hFD;
      4'd1:    s = 8'h05;
      4'd2:    s = 8'h7B;
      4'd3:    s = 8'h6F;
      4'd4:    s = 8'h87;
      4'd5:    s = 8'hEE;
      4'd6:    s = 8'hFE;
      4'd7:    s = 8'h45;
      4'd8:    s = 8'hFF;
      4'd9:    s = 8'hEF;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/erssd_front.sv]
`include "echo_range_seven_segment_display_assert.svh"

module erssd_front import erssd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  echo_i,
  input  logic                  cfg_we_i,
  input  logic [DWELL_BITS-1:0] cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COUNT_BITS-1:0] out_ticks_o,
  output beat_tag_t             out_tag_o
);

  localparam logic [COUNT_BITS-1:0] TICKS_MAX = '1;

  logic [COUNT_BITS-1:0] ticks_q, ticks_d;
  logic                  echo_prev_q;
  logic [DWELL_BITS-1:0] dwell_q;
  logic [DWELL_BITS-1:0] cnt_q, cnt_d;
  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic                  a_valid_q;
  logic [COUNT_BITS-1:0] a_ticks_q;
  beat_tag_t             a_tag_q;
  logic                  accept;
  logic                  falling;
  logic [DWELL_BITS-1:0] dwell_eff;
  logic [DWELL_BITS-1:0] cnt_inc;

  assign in_ready_o = !a_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign falling    = !echo_i && echo_prev_q;

  always_comb begin
    ticks_d = ticks_q;
    if (echo_i && !echo_prev_q) begin
      ticks_d = '0;
    end else if (echo_i && (ticks_q != TICKS_MAX)) begin
      ticks_d = ticks_q + 1'b1;
    end
  end

  always_comb begin
    dwell_eff = (dwell_q == '0) ? DWELL_BITS'(1) : dwell_q;
    cnt_inc   = cnt_q + 1'b1;
    if (cnt_inc >= dwell_eff) begin
      cnt_d = '0;
      pos_d = pos_q + 1'b1;
    end else begin
      cnt_d = cnt_inc;
      pos_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q     <= '0;
      echo_prev_q <= 1'b0;
      dwell_q     <= DWELL_RESET;
      cnt_q       <= '0;
      pos_q       <= '0;
      a_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dwell_q <= cfg_wdata_i;
      end
      if (accept) begin
        ticks_q     <= ticks_d;
        echo_prev_q <= echo_i;
        cnt_q       <= cnt_d;
        pos_q       <= pos_d;
      end
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_ticks_q    <= ticks_q;
      a_tag_q.done <= falling;
      a_tag_q.pos  <= pos_q;
    end
  end

  assign out_valid_o = a_valid_q;
  assign out_ticks_o = a_ticks_q;
  assign out_tag_o   = a_tag_q;

  `ERSSD_ASSERT_NEXT(a_fall_marks_done, accept && falling, a_valid_q && a_tag_q.done, "falling edge lost")
  `ERSSD_ASSERT_NEXT(a_ticks_saturate, accept && echo_i && echo_prev_q && (ticks_q == TICKS_MAX), ticks_q == TICKS_MAX, "echo counter wrapped")

endmodule

[hw/rtl/erssd_range.sv]
module erssd_range import erssd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COUNT_BITS-1:0] in_ticks_i,
  input  beat_tag_t             in_tag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DIST_BITS-1:0]  out_dist_o,
  output beat_tag_t             out_tag_o
);

  localparam int NDIV  = decade_stages(COUNT_BITS);
  localparam int TB    = COUNT_BITS + TICK_SHIFT;
  localparam int SHIFT = TB + CM_DIV_BITS;
  localparam int MB    = SHIFT - 4;
  localparam int ML    = (MB + 1) / 2;
  localparam int MH    = MB - ML;
  localparam int PLW   = TB + ML;
  localparam int PHW   = TB + MH;
  localparam int PW    = TB + MB;
  localparam int QB    = PW - SHIFT;
  localparam int S10   = QB + 4;
  localparam int XW    = 2 * QB + 1;

  localparam logic [63:0]   M_FULL = ((64'd1 << SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam logic [ML-1:0] M_LO   = M_FULL[ML-1:0];
  localparam logic [MH-1:0] M_HI   = M_FULL[MB-1:ML];
  localparam logic [63:0]   M10_FULL = ((64'd1 << S10) + 9) / 10;
  localparam logic [QB:0]   M10      = M10_FULL[QB:0];

  logic [TB-1:0]  t4;
  logic           b_valid_q;
  logic           b_ready;
  logic [PLW-1:0] b_lo_q;
  logic [PHW-1:0] b_hi_q;
  beat_tag_t      b_tag_q;
  logic [PW-1:0]  p_sum;

  logic [QB-1:0]  x_q   [NDIV+1];
  logic           v_q   [NDIV+1];
  beat_tag_t      tag_q [NDIV+1];
  logic           rdy   [NDIV+2];

  assign t4         = {in_ticks_i, {TICK_SHIFT{1'b0}}};
  assign b_ready    = !b_valid_q || rdy[0];
  assign in_ready_o = b_ready;
  assign rdy[NDIV+1] = out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && in_valid_i) begin
      b_lo_q  <= PLW'(t4) * PLW'(M_LO);
      b_hi_q  <= PHW'(t4) * PHW'(M_HI);
      b_tag_q <= in_tag_i;
    end
  end

  assign p_sum = PW'(b_lo_q) + (PW'(b_hi_q) << ML);

  genvar k;
  generate
    for (k = 0; k <= NDIV; k++) begin : g_ready
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && b_valid_q) begin
      x_q[0]   <= p_sum[SHIFT +: QB];
      tag_q[0] <= b_tag_q;
    end
  end

  generate
    for (k = 1; k <= NDIV; k++) begin : g_decade
      logic [XW-1:0] prod;
      logic [QB-1:0] nxt;

      assign prod = XW'(x_q[k-1]) * XW'(M10);
      assign nxt  = (x_q[k-1] > DIST_MAX) ? QB'(prod[S10 +: QB-3]) : x_q[k-1];

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (rdy[k] && v_q[k-1]) begin
          x_q[k]   <= nxt;
          tag_q[k] <= tag_q[k-1];
        end
      end
    end
  endgenerate

  assign out_valid_o = v_q[NDIV];
  assign out_dist_o  = DIST_BITS'(x_q[NDIV]);
  assign out_tag_o   = tag_q[NDIV];

endmodule

[hw/rtl/erssd_digits.sv]
module erssd_digits import erssd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [DIST_BITS-1:0] in_dist_i,
  input  beat_tag_t            in_tag_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DIST_BITS-1:0] out_dist_o,
  output bcd_word_t            out_digits_o,
  output beat_tag_t            out_tag_o
);

  localparam int S1  = DIST_BITS + 4;
  localparam int S2  = DIST_BITS + 7;
  localparam int S3  = DIST_BITS + 10;
  localparam int MW  = 15;
  localparam int PRW = DIST_BITS + MW;
  localparam int Q1W = 10;
  localparam int Q2W = 7;
  localparam int Q3W = BCD_BITS;

  localparam logic [63:0] M1_FULL = ((64'd1 << S1) + 9) / 10;
  localparam logic [63:0] M2_FULL = ((64'd1 << S2) + 99) / 100;
  localparam logic [63:0] M3_FULL = ((64'd1 << S3) + 999) / 1000;
  localparam logic [MW-1:0] M1 = M1_FULL[MW-1:0];
  localparam logic [MW-1:0] M2 = M2_FULL[MW-1:0];
  localparam logic [MW-1:0] M3 = M3_FULL[MW-1:0];

  logic                 e_valid_q, f_valid_q;
  logic                 e_ready, f_ready;
  logic [DIST_BITS-1:0] e_x_q, f_x_q;
  logic [Q1W-1:0]       e_q1_q;
  logic [Q2W-1:0]       e_q2_q;
  logic [Q3W-1:0]       e_q3_q;
  beat_tag_t            e_tag_q, f_tag_q;
  bcd_word_t            f_digits_q;
  logic [PRW-1:0]       p1, p2, p3;
  logic [DIST_BITS-1:0] r0;
  logic [Q1W-1:0]       r1;
  logic [Q2W-1:0]       r2;

  assign f_ready    = !f_valid_q || out_ready_i;
  assign e_ready    = !e_valid_q || f_ready;
  assign in_ready_o = e_ready;

  assign p1 = PRW'(in_dist_i) * PRW'(M1);
  assign p2 = PRW'(in_dist_i) * PRW'(M2);
  assign p3 = PRW'(in_dist_i) * PRW'(M3);

  assign r0 = e_x_q - ((DIST_BITS'(e_q1_q) << 3) + (DIST_BITS'(e_q1_q) << 1));
  assign r1 = e_q1_q - ((Q1W'(e_q2_q) << 3) + (Q1W'(e_q2_q) << 1));
  assign r2 = e_q2_q - ((Q2W'(e_q3_q) << 3) + (Q2W'(e_q3_q) << 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      if (e_ready) begin
        e_valid_q <= in_valid_i;
      end
      if (f_ready) begin
        f_valid_q <= e_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_ready && in_valid_i) begin
      e_x_q   <= in_dist_i;
      e_q1_q  <= p1[S1 +: Q1W];
      e_q2_q  <= p2[S2 +: Q2W];
      e_q3_q  <= p3[S3 +: Q3W];
      e_tag_q <= in_tag_i;
    end
    if (f_ready && e_valid_q) begin
      f_x_q         <= e_x_q;
      f_digits_q[0] <= BCD_BITS'(r0);
      f_digits_q[1] <= BCD_BITS'(r1);
      f_digits_q[2] <= BCD_BITS'(r2);
      f_digits_q[3] <= e_q3_q;
      f_tag_q       <= e_tag_q;
    end
  end

  assign out_valid_o  = f_valid_q;
  assign out_dist_o   = f_x_q;
  assign out_digits_o = f_digits_q;
  assign out_tag_o    = f_tag_q;

endmodule

[hw/rtl/erssd_display.sv]
`include "echo_range_seven_segment_display_assert.svh"

module erssd_display import erssd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DIST_BITS-1:0]  in_dist_i,
  input  bcd_word_t             in_digits_i,
  input  beat_tag_t             in_tag_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SEG_BITS-1:0]   seg_o,
  output logic [NUM_DIGITS-1:0] sel_o,
  output logic [DIST_BITS-1:0]  dist_o,
  output logic                  done_o
);

  logic [DIST_BITS-1:0]  store_dist_q, new_dist;
  bcd_word_t             store_digits_q, new_digits;
  logic                  valid_q;
  logic                  take;
  logic [SEG_BITS-1:0]   seg_q;
  logic [NUM_DIGITS-1:0] sel_q;
  logic [DIST_BITS-1:0]  dist_q;
  logic                  done_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign new_dist   = in_tag_i.done ? in_dist_i : store_dist_q;
  assign new_digits = in_tag_i.done ? in_digits_i : store_digits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= 1'b0;
      store_dist_q   <= '0;
      store_digits_q <= '0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (take && in_tag_i.done) begin
        store_dist_q   <= in_dist_i;
        store_digits_q <= in_digits_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      seg_q  <= seg_of(new_digits[in_tag_i.pos]);
      sel_q  <= ~(NUM_DIGITS'(1) << in_tag_i.pos);
      dist_q <= new_dist;
      done_q <= in_tag_i.done;
    end
  end

  assign out_valid_o = valid_q;
  assign seg_o       = seg_q;
  assign sel_o       = sel_q;
  assign dist_o      = dist_q;
  assign done_o      = done_q;

  `ERSSD_ASSERT_SAME(a_one_digit_lit, valid_q, $onehot(~sel_q), "digit select not one-cold")
  `ERSSD_ASSERT_SAME(a_dist_in_range, valid_q, dist_q <= DIST_MAX, "distance above four digits")
  `ERSSD_ASSERT_NEXT(a_store_update, take && in_tag_i.done, store_dist_q == $past(in_dist_i), "distance not stored")

endmodule

[hw/rtl/echo_range_seven_segment_display.sv]
// A beat passes the front register, then the range registers with the N divide-by-ten stages
// that COUNT_BITS needs (N = 0 at 16 bits, 5 at 32 bits), then the digit and display
// registers. Throughput: one beat per cycle unless m_axis_tready stalls; every stage is a
// register with its own valid bit. Reset clears the echo counter, edge history, dwell
// counter, digit position and stored distance, and loads the dwell register with 625.
module echo_range_seven_segment_display import erssd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // Bit 0: echo_level; the rest is zero fill.
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // Bits 7:0 segments, 11:8 digit_select, 25:12 distance_cm, 26 measurement_done.
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  input  logic                      cfg_we_i,
  input  logic [DWELL_BITS-1:0]     cfg_wdata_i
);

  localparam int PAD_BITS = OUT_TDATA_BITS - SEG_BITS - NUM_DIGITS - DIST_BITS - 1;

  logic                  a_valid, a_ready;
  logic [COUNT_BITS-1:0] a_ticks;
  beat_tag_t             a_tag;
  logic                  r_valid, r_ready;
  logic [DIST_BITS-1:0]  r_dist;
  beat_tag_t             r_tag;
  logic                  d_valid, d_ready;
  logic [DIST_BITS-1:0]  d_dist;
  bcd_word_t             d_digits;
  beat_tag_t             d_tag;
  logic [SEG_BITS-1:0]   seg;
  logic [NUM_DIGITS-1:0] sel;
  logic [DIST_BITS-1:0]  distance;
  logic                  done;

  erssd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .echo_i      (s_axis_tdata[0]),
    .cfg_we_i,
    .cfg_wdata_i,
    .out_valid_o (a_valid),
    .out_ready_i (a_ready),
    .out_ticks_o (a_ticks),
    .out_tag_o   (a_tag)
  );

  erssd_range #(.COUNT_BITS(COUNT_BITS)) u_range (
    .clk_i,
    .rst_ni,
    .in_valid_i  (a_valid),
    .in_ready_o  (a_ready),
    .in_ticks_i  (a_ticks),
    .in_tag_i    (a_tag),
    .out_valid_o (r_valid),
    .out_ready_i (r_ready),
    .out_dist_o  (r_dist),
    .out_tag_o   (r_tag)
  );

  erssd_digits u_digits (
    .clk_i,
    .rst_ni,
    .in_valid_i   (r_valid),
    .in_ready_o   (r_ready),
    .in_dist_i    (r_dist),
    .in_tag_i     (r_tag),
    .out_valid_o  (d_valid),
    .out_ready_i  (d_ready),
    .out_dist_o   (d_dist),
    .out_digits_o (d_digits),
    .out_tag_o    (d_tag)
  );

  erssd_display u_display (
    .clk_i,
    .rst_ni,
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .in_dist_i   (d_dist),
    .in_digits_i (d_digits),
    .in_tag_i    (d_tag),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .seg_o       (seg),
    .sel_o       (sel),
    .dist_o      (distance),
    .done_o      (done)
  );

  assign m_axis_tdata = {{PAD_BITS{1'b0}}, done, distance, sel, seg};

endmodule

[bench/tb_top.sv]
`default_nettype none

module tb_top;
  import erssd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int US_PER_TICK = 8;
  localparam int US_PER_CM = 58;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [9:0][SEG_BITS-1:0] SEG_PATTERN = {
    8'hEF, 8'hFF, 8'h45, 8'hFE, 8'hEE, 8'h87, 8'h6F, 8'h7B, 8'h05, 8'hFD
  };

  typedef struct packed {
    logic [4:0]           fill;
    logic                 done;
    logic [DIST_BITS-1:0] distance;
    logic [3:0]           sel;
    logic [SEG_BITS-1:0]  seg;
  } display_beat_t;

  typedef struct packed {
    logic          echo;
    logic          typed;
    display_beat_t want;
  } directed_row_t;

  localparam display_beat_t ANY_BEAT = '0;
  localparam display_beat_t ZERO_SHOWN = '{5'd0, 1'b0, 14'd0, 4'b1110, 8'hFD};
  localparam display_beat_t ZERO_STORED = '{5'd0, 1'b1, 14'd0, 4'b1110, 8'hFD};
  localparam int NUM_DIRECTED = 22;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      cfg_we_i = 1'b0;
  logic [DWELL_BITS-1:0]     cfg_wdata_i = '0;

  logic [COUNT_BITS_DEFAULT-1:0] echo_ticks;
  logic                          echo_last;
  logic [DIST_BITS-1:0]          distance_shown;
  logic [POS_BITS-1:0]           digit_pos;
  logic [DWELL_BITS-1:0]         dwell_count;
  logic [DWELL_BITS-1:0]         dwell_ticks;

  display_beat_t pending_displays[$];
  directed_row_t directed_rows[NUM_DIRECTED];
  int            mismatch_count = 0;
  int            items_sent = 0;
  int            cycle_count = 0;
  int            idle_level = 2;
  int            ready_hold = 0;

  echo_range_seven_segment_display DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (idle_level == 0) return 0;
    if (idle_level == 1) return (pick < 50) ? 0 : $urandom_range(1, 3);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic display_beat_t predict_display(logic echo);
    display_beat_t    beat;
    longint unsigned  cm;
    int unsigned      value;
    logic [DWELL_BITS-1:0] dwell;
    beat = '0;
    if (echo && !echo_last) begin
      echo_ticks = '0;
    end else if (echo) begin
      if (echo_ticks != '1) echo_ticks = echo_ticks + 1'b1;
    end else if (echo_last) begin
      cm = (64'(echo_ticks) * US_PER_TICK) / US_PER_CM;
      while (cm > DIST_MAX) cm = cm / 10;
      distance_shown = cm[DIST_BITS-1:0];
      beat.done = 1'b1;
    end
    echo_last = echo;

    value = distance_shown;
    for (int k = 0; k < digit_pos; k++) value = value / 10;
    beat.seg = SEG_PATTERN[value % 10];
    beat.sel = ~(4'b0001 << digit_pos);
    beat.distance = distance_shown;

    dwell = (dwell_ticks == '0) ? DWELL_BITS'(1) : dwell_ticks;
    dwell_count = dwell_count + 1'b1;
    if (dwell_count >= dwell) begin
      dwell_count = '0;
      digit_pos = digit_pos + 1'b1;
    end
    return beat;
  endfunction

  task automatic send_echo(input logic echo, input logic typed, input display_beat_t want);
    int gap;
    display_beat_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_BITS-1){1'b0}}, echo};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_display(echo);
    pending_displays.push_back(typed ? want : predicted);
    items_sent++;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_level(input logic echo, input int ticks);
    repeat (ticks) send_echo(echo, 1'b0, ANY_BEAT);
  endtask

  task automatic wait_all_shown();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_displays.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_dwell(input logic [DWELL_BITS-1:0] ticks);
    wait_all_shown();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dwell_ticks = ticks;
  endtask

  // Mostly clean low/high echo pulses, with some per-tick noise mixed in.
  task automatic run_pulses(input int quota);
    int start;
    int pick;
    start = items_sent;
    while (items_sent - start < quota) begin
      pick = $urandom_range(0, 9);
      idle_level = (pick == 0) ? 0 : (pick < 3) ? 1 : 2;
      if ($urandom_range(0, 99) < 80) begin
        send_level(1'b0, $urandom_range(1, 6));
        if ($urandom_range(0, 3) != 0) send_level(1'b1, $urandom_range(1, 40));
        else send_level(1'b1, $urandom_range(41, 400));
      end else begin
        repeat ($urandom_range(1, 10)) send_echo(1'($urandom_range(0, 1)), 1'b0, ANY_BEAT);
      end
    end
    send_echo(1'b0, 1'b0, ANY_BEAT);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      m_axis_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold <= idle_cycles();
    end
  end

  always @(posedge clk_i) begin
    display_beat_t got;
    display_beat_t want;
    got = m_axis_tdata;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_displays.size() == 0) begin
        $display("%0t ns: display beat %h with nothing expected", $time, got);
        mismatch_count++;
      end else begin
        want = pending_displays.pop_front();
        compare_field("segments", want.seg, got.seg);
        compare_field("digit_select", want.sel, got.sel);
        compare_field("distance_cm", want.distance, got.distance);
        compare_field("measurement_done", want.done, got.done);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats outstanding", cycle_count,
               pending_displays.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    echo_ticks = '0;
    echo_last = 1'b0;
    distance_shown = '0;
    digit_pos = '0;
    dwell_count = '0;
    dwell_ticks = DWELL_RESET;

    directed_rows = '{
      '{1'b0, 1'b1, ZERO_SHOWN},
      '{1'b1, 1'b1, ZERO_SHOWN},
      '{1'b0, 1'b1, ZERO_STORED},
      '{1'b0, 1'b1, ZERO_SHOWN},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b0, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b0, 1'b1, ZERO_STORED},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b0, 1'b0, ANY_BEAT},
      '{1'b1, 1'b0, ANY_BEAT},
      '{1'b0, 1'b0, ANY_BEAT},
      '{1'b0, 1'b0, ANY_BEAT}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_echo(directed_rows[i].echo, directed_rows[i].typed, directed_rows[i].want);
    end

    run_pulses(220);
    write_dwell(16'd1);
    run_pulses(220);
    write_dwell(16'd0);
    run_pulses(220);
    write_dwell(16'hFFFF);
    run_pulses(220);
    // The dwell count is now far above seven, so the digit moves on at once.
    write_dwell(16'd7);
    run_pulses(220);

    wait_all_shown();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
